FILE: hdl/amgs_pkg.sv
// Package for the adjacency matrix graph store.
// Holds sizes, the item payload structs, the operation codes and the
// controller to datapath command and status types. Depends on nothing.
`default_nettype none

package amgs_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VID_W        = 6;
    localparam int ORDER_W      = 7;
    localparam int DEG_W        = 6;
    localparam int EDGE_W       = 11;

    typedef enum logic [2:0] {
        FN_ADD_EDGE    = 3'd0,
        FN_REMOVE_EDGE = 3'd1,
        FN_REMOVE_VERT = 3'd2,
        FN_QUERY_EDGE  = 3'd3,
        FN_DEGREE      = 3'd4,
        FN_STATS       = 3'd5
    } amgs_func_t;

    typedef struct packed {
        logic [2:0]       func;
        logic [VID_W-1:0] first_vertex;
        logic [VID_W-1:0] second_vertex;
    } amgs_in_t;

    typedef struct packed {
        logic               status;
        logic               edge_present;
        logic [DEG_W-1:0]   vertex_degree;
        logic               is_isolated;
        logic [ORDER_W-1:0] vertex_count;
        logic [EDGE_W-1:0]  edge_count;
        logic [DEG_W-1:0]   low_degree;
        logic [DEG_W-1:0]   high_degree;
    } amgs_out_t;

    typedef struct packed {
        logic [DEG_W-1:0]        deg;
        logic [MAX_VERTICES-1:0] row;
    } amgs_word_t;

    typedef enum logic [1:0] {
        SEL_U,
        SEL_V,
        SEL_I
    } amgs_sel_t;

    typedef enum logic [1:0] {
        WR_SET,
        WR_CLR,
        WR_ZERO
    } amgs_wr_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RD_U,
        ST_EDGE_U,
        ST_EDGE_V,
        ST_NBR,
        ST_SCAN,
        ST_CLR,
        ST_ZERO,
        ST_STAT,
        ST_STAT_END,
        ST_DONE
    } amgs_state_t;

    typedef struct packed {
        logic        latch;
        logic        mem_rd;
        amgs_sel_t   rd_sel;
        logic        mem_wr;
        amgs_sel_t   wr_sel;
        amgs_wr_op_t wr_op;
        logic        edge_inc;
        logic        edge_dec;
        logic        save_nbr;
        logic        idx_inc;
        logic        stat_step;
        logic        set_removed;
        logic        res_load;
    } amgs_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       u_eq_v;
        logic       u_present;
        logic       v_present;
        logic       edge_bit;
        logic       nbr_bit;
        logic       idx_max;
        logic       idx_order_end;
    } amgs_status_t;

endpackage

`default_nettype wire

FILE: hdl/adjacency_matrix_graph_store.sv
// Adjacency matrix graph store, top level.
// The input channel (s_valid, s_ready, s_data) takes one operation item:
// add edge, remove edge, remove vertex, query edge, degree or statistics.
// Every item gives exactly one result item on m_valid, m_ready, m_data.
// The cfg channel writes the vertex order and clears the whole graph; it
// is taken only while no item is in progress. Items are worked one at a
// time; the next item is taken only after a result is loaded. An edge
// operation reads the row of the first vertex and, when it changes the
// graph, rewrites both rows; a self loop or an absent vertex goes straight
// to the result. Edge and degree queries read the row of the first vertex.
// Statistics read one degree entry per cycle over the vertex order. Remove
// vertex scans all 64 neighbor bits, one per cycle while no row is
// rewritten; the scan holds while each neighbor's row is rewritten, and an
// absent vertex goes straight to the result.
// A finished result waits in an output register; while the receiver stalls
// the block holds at most one more finished item before it stops accepting.
// Reset is synchronous and active low; it empties the graph at once through
// per-row valid bits and sets the vertex order to 64.
// Depends on amgs_pkg, amgs_ctrl and amgs_dp.
`default_nettype none

module adjacency_matrix_graph_store
    import amgs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire amgs_in_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output amgs_out_t       m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [6:0] cfg_data
);

    amgs_cmd_t    cmd;
    amgs_status_t stat;

    amgs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    amgs_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .in_item  (s_data),
        .cmd      (cmd),
        .stat     (stat),
        .result   (m_data)
    );

endmodule

`default_nettype wire

FILE: hdl/amgs_dp.sv
// Datapath of the adjacency matrix graph store: row memory with degrees,
// row valid bits, removed mask, edge count, scan index and statistics.
// Depends on amgs_pkg; driven by amgs_ctrl through amgs_cmd_t.
`default_nettype none

module amgs_dp
    import amgs_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [6:0]   cfg_data,
    input  wire amgs_in_t     in_item,
    input  wire amgs_cmd_t    cmd,
    output amgs_status_t      stat,
    output amgs_out_t         result
);

    amgs_word_t              mem [MAX_VERTICES];
    amgs_word_t              rdata_reg;
    logic                    rvld_reg;
    amgs_word_t              rd_word;
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic [MAX_VERTICES-1:0] removed_reg;
    logic [ORDER_W-1:0]      order_reg;
    logic [ORDER_W-1:0]      order_next;
    logic [EDGE_W-1:0]       edges_reg;

    logic [2:0]              func_reg;
    logic [VID_W-1:0]        u_reg;
    logic [VID_W-1:0]        v_reg;
    logic                    pu_reg;
    logic                    pv_reg;
    logic [VID_W-1:0]        idx_reg;
    logic [MAX_VERTICES-1:0] nbr_reg;

    logic                    stat_pend_reg;
    logic [VID_W-1:0]        stat_idx_reg;
    logic [ORDER_W-1:0]      cnt_reg;
    logic [DEG_W-1:0]        lo_reg;
    logic [DEG_W-1:0]        hi_reg;
    logic                    stat_present;

    logic                    in_pu;
    logic                    in_pv;
    logic [VID_W-1:0]        raddr;
    logic [VID_W-1:0]        waddr;
    logic [VID_W-1:0]        bit_pos;
    amgs_word_t              wdata;
    amgs_out_t               res_next;

    assign rd_word = rvld_reg ? rdata_reg : '0;

    assign in_pu = ({1'b0, in_item.first_vertex} < order_reg)
                   && !removed_reg[in_item.first_vertex];
    assign in_pv = ({1'b0, in_item.second_vertex} < order_reg)
                   && !removed_reg[in_item.second_vertex];

    always_comb begin
        case (cmd.rd_sel)
            SEL_U:   raddr = u_reg;
            SEL_V:   raddr = v_reg;
            default: raddr = idx_reg;
        endcase
        case (cmd.wr_sel)
            SEL_U:   waddr = u_reg;
            SEL_V:   waddr = v_reg;
            default: waddr = idx_reg;
        endcase
        bit_pos = (cmd.wr_sel == SEL_U) ? v_reg : u_reg;
        wdata   = rd_word;
        case (cmd.wr_op)
            WR_SET: begin
                wdata.row[bit_pos] = 1'b1;
                wdata.deg          = rd_word.deg + 1'b1;
            end
            WR_CLR: begin
                wdata.row[bit_pos] = 1'b0;
                wdata.deg          = rd_word.deg - 1'b1;
            end
            default: begin
                wdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[waddr] <= wdata;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mem[raddr];
            rvld_reg  <= row_valid_reg[raddr];
        end
    end

    always_comb begin
        if (cfg_data == '0) begin
            order_next = ORDER_W'(1);
        end else if (cfg_data > ORDER_W'(MAX_VERTICES)) begin
            order_next = ORDER_W'(MAX_VERTICES);
        end else begin
            order_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            removed_reg   <= '0;
            edges_reg     <= '0;
            order_reg     <= ORDER_W'(MAX_VERTICES);
            stat_pend_reg <= 1'b0;
        end else begin
            stat_pend_reg <= cmd.stat_step;
            if (cfg_we) begin
                row_valid_reg <= '0;
                removed_reg   <= '0;
                edges_reg     <= '0;
                order_reg     <= order_next;
            end else begin
                if (cmd.mem_wr) begin
                    row_valid_reg[waddr] <= 1'b1;
                end
                if (cmd.set_removed) begin
                    removed_reg[u_reg] <= 1'b1;
                end
                if (cmd.edge_inc) begin
                    edges_reg <= edges_reg + 1'b1;
                end else if (cmd.edge_dec) begin
                    edges_reg <= edges_reg - 1'b1;
                end
            end
        end
    end

    assign stat_present = ({1'b0, stat_idx_reg} < order_reg) && !removed_reg[stat_idx_reg];

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            func_reg <= in_item.func;
            u_reg    <= in_item.first_vertex;
            v_reg    <= in_item.second_vertex;
            pu_reg   <= in_pu;
            pv_reg   <= in_pv;
            idx_reg  <= '0;
            cnt_reg  <= '0;
            lo_reg   <= '0;
            hi_reg   <= '0;
        end else begin
            if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (stat_pend_reg && stat_present) begin
                if (cnt_reg == '0 || rd_word.deg < lo_reg) begin
                    lo_reg <= rd_word.deg;
                end
                if (rd_word.deg > hi_reg) begin
                    hi_reg <= rd_word.deg;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (cmd.save_nbr) begin
            nbr_reg <= rd_word.row;
        end
        if (cmd.stat_step) begin
            stat_idx_reg <= idx_reg;
        end
        if (cmd.res_load) begin
            result <= res_next;
        end
    end

    always_comb begin
        res_next = '0;
        case (func_reg)
            FN_ADD_EDGE: begin
                res_next.status = (u_reg != v_reg) && !(pu_reg && pv_reg);
            end
            FN_REMOVE_EDGE: begin
                res_next.status = !(pu_reg && pv_reg);
            end
            FN_REMOVE_VERT: begin
                res_next.status = !pu_reg;
            end
            FN_QUERY_EDGE: begin
                res_next.edge_present = pu_reg && pv_reg && rd_word.row[v_reg];
            end
            FN_DEGREE: begin
                res_next.status        = !pu_reg;
                res_next.vertex_degree = pu_reg ? rd_word.deg : '0;
                res_next.is_isolated   = pu_reg && (rd_word.deg == '0);
            end
            FN_STATS: begin
                res_next.vertex_count = cnt_reg;
                res_next.edge_count   = edges_reg;
                res_next.low_degree   = lo_reg;
                res_next.high_degree  = hi_reg;
            end
            default: begin
                res_next = '0;
            end
        endcase
    end

    assign stat.func          = func_reg;
    assign stat.u_eq_v        = (u_reg == v_reg);
    assign stat.u_present     = pu_reg;
    assign stat.v_present     = pv_reg;
    assign stat.edge_bit      = rd_word.row[v_reg];
    assign stat.nbr_bit       = nbr_reg[idx_reg];
    assign stat.idx_max       = (idx_reg == VID_W'(MAX_VERTICES - 1));
    assign stat.idx_order_end = ({1'b0, idx_reg} == (order_reg - 1'b1));

endmodule

`default_nettype wire

FILE: hdl/amgs_ctrl.sv
// Controller of the adjacency matrix graph store: handshakes and the
// operation sequencer. Depends on amgs_pkg; drives amgs_dp by amgs_cmd_t.
`default_nettype none

module amgs_ctrl
    import amgs_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire amgs_status_t  stat,
    output amgs_cmd_t          cmd
);

    amgs_state_t state_reg;
    amgs_state_t state_next;
    logic        out_valid_reg;
    logic        edge_set;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_valid   = out_valid_reg;
    assign edge_set  = (stat.func == FN_ADD_EDGE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.res_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.func)
                    FN_ADD_EDGE, FN_REMOVE_EDGE: begin
                        if (stat.u_eq_v || !(stat.u_present && stat.v_present)) begin
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_RD_U;
                        end
                    end
                    FN_REMOVE_VERT: begin
                        state_next = stat.u_present ? ST_RD_U : ST_DONE;
                    end
                    FN_QUERY_EDGE, FN_DEGREE: begin
                        state_next = ST_RD_U;
                    end
                    FN_STATS: begin
                        state_next = ST_STAT;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RD_U: begin
                case (stat.func)
                    FN_ADD_EDGE, FN_REMOVE_EDGE: state_next = ST_EDGE_U;
                    FN_REMOVE_VERT:              state_next = ST_NBR;
                    default:                     state_next = ST_DONE;
                endcase
            end
            ST_EDGE_U: begin
                if (stat.edge_bit == edge_set) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_EDGE_V;
                end
            end
            ST_EDGE_V: begin
                state_next = ST_DONE;
            end
            ST_NBR: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (stat.nbr_bit) begin
                    state_next = ST_CLR;
                end else if (stat.idx_max) begin
                    state_next = ST_ZERO;
                end
            end
            ST_CLR: begin
                state_next = stat.idx_max ? ST_ZERO : ST_SCAN;
            end
            ST_ZERO: begin
                state_next = ST_DONE;
            end
            ST_STAT: begin
                if (stat.idx_order_end) begin
                    state_next = ST_STAT_END;
                end
            end
            ST_STAT_END: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.latch = s_valid && s_ready;
            end
            ST_RD_U: begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = SEL_U;
            end
            ST_EDGE_U: begin
                if (stat.edge_bit != edge_set) begin
                    cmd.mem_wr = 1'b1;
                    cmd.wr_sel = SEL_U;
                    cmd.wr_op  = edge_set ? WR_SET : WR_CLR;
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = SEL_V;
                end
            end
            ST_EDGE_V: begin
                cmd.mem_wr   = 1'b1;
                cmd.wr_sel   = SEL_V;
                cmd.wr_op    = edge_set ? WR_SET : WR_CLR;
                cmd.edge_inc = edge_set;
                cmd.edge_dec = !edge_set;
            end
            ST_NBR: begin
                cmd.save_nbr = 1'b1;
            end
            ST_SCAN: begin
                if (stat.nbr_bit) begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = SEL_I;
                end else if (!stat.idx_max) begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_CLR: begin
                cmd.mem_wr   = 1'b1;
                cmd.wr_sel   = SEL_I;
                cmd.wr_op    = WR_CLR;
                cmd.edge_dec = 1'b1;
                cmd.idx_inc  = !stat.idx_max;
            end
            ST_ZERO: begin
                cmd.mem_wr      = 1'b1;
                cmd.wr_sel      = SEL_U;
                cmd.wr_op       = WR_ZERO;
                cmd.set_removed = 1'b1;
            end
            ST_STAT: begin
                cmd.mem_rd    = 1'b1;
                cmd.rd_sel    = SEL_I;
                cmd.stat_step = 1'b1;
                cmd.idx_inc   = !stat.idx_order_end;
            end
            ST_DONE: begin
                cmd.res_load = !out_valid_reg || m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire
